FILE: hdl/imu_tcf_pkg.sv
// Package for the IMU tilt complementary filter: shared types, constants, CORDIC table.
// No dependencies.
`timescale 1ns / 1ps
package imu_tcf_pkg;

    localparam int AXES        = 3;
    localparam int TABLE_LEN   = 24;
    localparam int ZW          = 32;   // angle accumulator width, 2^-24 degree units
    localparam int CW          = 42;   // CORDIC x/y width
    localparam int ACC_W       = 16;
    localparam int TILT_W      = 24;
    localparam int WEIGHT_W    = 9;
    localparam int STEP_W      = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME    = 1'b1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd128;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd200;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // capture input word
        logic [1:0] axis;       // axis being processed
        logic       sqrt_init;
        logic       sqrt_step;
        logic       cor_init;
        logic       cor_step;
        logic       gyro_mul;
        logic       gyro_div;
        logic       blend_mul;
        logic       store;      // write blended angle and result
    } imu_tcf_cmd_t;

    // atan(2^-i) in degrees, units of 2^-24 degree
    function automatic logic [ZW-1:0] atan_lut(input logic [4:0] i);
        case (i)
            5'd0:  atan_lut = 32'd754974720;
            5'd1:  atan_lut = 32'd445687602;
            5'd2:  atan_lut = 32'd235489088;
            5'd3:  atan_lut = 32'd119537938;
            5'd4:  atan_lut = 32'd60000934;
            5'd5:  atan_lut = 32'd30029717;
            5'd6:  atan_lut = 32'd15018523;
            5'd7:  atan_lut = 32'd7509720;
            5'd8:  atan_lut = 32'd3754917;
            5'd9:  atan_lut = 32'd1877466;
            5'd10: atan_lut = 32'd938734;
            5'd11: atan_lut = 32'd469367;
            5'd12: atan_lut = 32'd234684;
            5'd13: atan_lut = 32'd117342;
            5'd14: atan_lut = 32'd58671;
            5'd15: atan_lut = 32'd29335;
            5'd16: atan_lut = 32'd14668;
            5'd17: atan_lut = 32'd7334;
            5'd18: atan_lut = 32'd3667;
            5'd19: atan_lut = 32'd1833;
            5'd20: atan_lut = 32'd917;
            5'd21: atan_lut = 32'd458;
            5'd22: atan_lut = 32'd229;
            5'd23: atan_lut = 32'd115;
            default: atan_lut = '0;
        endcase
    endfunction

endpackage

FILE: hdl/imu_tcf_if.sv
// Valid/ready channel interfaces for the tilt filter sample and result words.
// Depends on imu_tcf_pkg.
`timescale 1ns / 1ps
interface imu_tcf_in_if import imu_tcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic signed [ACC_W-1:0] rate_x;
    logic signed [ACC_W-1:0] rate_y;
    logic signed [ACC_W-1:0] rate_z;
    modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                    output ready);
endinterface

interface imu_tcf_out_if import imu_tcf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic signed [TILT_W-1:0] tilt_x;
    logic signed [TILT_W-1:0] tilt_y;
    logic signed [TILT_W-1:0] tilt_z;
    modport source (output valid, tilt_x, tilt_y, tilt_z, input ready);
    modport sink   (input valid, tilt_x, tilt_y, tilt_z, output ready);
endinterface

FILE: hdl/imu_tcf_ctrl.sv
// Controller FSM for the tilt filter: sequences sqrt, CORDIC, gyro and blend per axis.
// Depends on imu_tcf_pkg.
`timescale 1ns / 1ps
module imu_tcf_ctrl
    import imu_tcf_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output imu_tcf_cmd_t cmd
);

    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SQI   = 9'b000000010,
        S_SQ    = 9'b000000100,
        S_CI    = 9'b000001000,
        S_CS    = 9'b000010000,
        S_GM    = 9'b000100000,
        S_GD    = 9'b001000000,
        S_BM    = 9'b010000000,
        S_ST    = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;
    logic       ovalid_reg, ovalid_next;

    // Input is taken whenever the sequencer is idle; the result word has its own register
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        axis_next   = axis_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.axis    = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = 2'd0;
                    state_next = S_SQI;
                end
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQ;
            end
            S_SQ:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                    state_next = S_CI;
            end
            S_CI:
            begin
                cmd.cor_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_CS;
            end
            S_CS:
            begin
                cmd.cor_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(NSTEPS - 1))
                    state_next = S_GM;
            end
            S_GM:
            begin
                cmd.gyro_mul = 1'b1;
                state_next   = S_GD;
            end
            S_GD:
            begin
                cmd.gyro_div = 1'b1;
                state_next   = S_BM;
            end
            S_BM:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_ST;
            end
            S_ST:
            begin
                if (axis_reg == 2'd2)
                begin
                    // last axis waits until the result register is free
                    if (!ovalid_reg || out_ready)
                    begin
                        cmd.store   = 1'b1;
                        ovalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cmd.store  = 1'b1;
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SQI;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            axis_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            axis_reg   <= axis_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTHESIS
    // Result word appears only after the last axis is stored
    a_out_after_store: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == S_ST && axis_reg == 2'd2))
        else $error("result raised without final store");
    // Pending result is never dropped while not taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ready |=> ovalid_reg)
        else $error("result lost");
    // Axis stays in range
    a_axis: assert property (@(posedge clk) disable iff (!rst_n) axis_reg != 2'd3)
        else $error("axis out of range");
`endif

endmodule

FILE: hdl/imu_tcf_dp.sv
// Datapath for the tilt filter: bit-serial sqrt, shared CORDIC, gyro and blend arithmetic.
// Depends on imu_tcf_pkg.
`timescale 1ns / 1ps
module imu_tcf_dp
    import imu_tcf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  imu_tcf_cmd_t               cmd,
    input  logic signed [ACC_W-1:0]    accel_x,
    input  logic signed [ACC_W-1:0]    accel_y,
    input  logic signed [ACC_W-1:0]    accel_z,
    input  logic signed [ACC_W-1:0]    rate_x,
    input  logic signed [ACC_W-1:0]    rate_y,
    input  logic signed [ACC_W-1:0]    rate_z,
    input  logic [WEIGHT_W-1:0]        blend_weight,
    input  logic [STEP_W-1:0]          step_time_ms,
    output logic signed [TILT_W-1:0]   tilt_x,
    output logic signed [TILT_W-1:0]   tilt_y,
    output logic signed [TILT_W-1:0]   tilt_z
);

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int GNW   = ACC_W + STEP_W + F + 1;   // signed gyro numerator
    localparam int GMW   = GNW - 1;                   // its magnitude
    localparam int RW    = 10;                        // 1/1000 reciprocal shift margin
    localparam int RSH   = GMW + RW;
    localparam logic [RSH:0] RECIP = (RSH+1)'(((64'd1 << RSH) + 64'd999) / 64'd1000);
    localparam int BW    = 40;                        // blend product width
    localparam logic signed [ZW-1:0] RND_Z = ZW'(64'd1 << (23 - F));
    localparam logic signed [TILT_W-1:0] DEG90 = TILT_W'(90 << F);

    // Captured sample
    logic signed [ACC_W-1:0] ax_reg, ay_reg, az_reg, rx_reg, ry_reg, rz_reg;
    logic signed [TILT_W-1:0] ang_reg [AXES];
    logic signed [TILT_W-1:0] res_reg [AXES];

    logic signed [ACC_W-1:0] a_sel, b_sel, c_sel, r_sel;

    // Sqrt
    logic [32:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [33:0] sq_trial;
    logic [31:0] rad_reg;

    // CORDIC
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           i_reg;
    logic signed [CW-1:0] xs, ys;

    // Gyro and blend
    logic [GMW-1:0]          gmag_reg;
    logic                    gneg_reg;
    logic signed [TILT_W+1:0] acc_reg;
    logic signed [TILT_W+2:0] gyro_reg;
    logic signed [BW-1:0]    sum_reg;
    logic signed [GNW-1:0]   gnum;
    logic [RSH+GMW:0]        qprod;
    logic [GMW-1:0]          q0_reg;
    logic [GMW+1:0]          r0;
    logic [GMW-1:0]          q1;
    logic [9:0]              w_eff;
    logic signed [ZW-1:0]    z_rnd;
    logic signed [TILT_W+1:0] cor_ang;
    logic signed [BW-1:0]    vsh;
    logic signed [TILT_W-1:0] vsat;

    // Axis operand select
    always_comb
    begin
        case (cmd.axis)
            2'd0:    begin a_sel = ax_reg; b_sel = ay_reg; c_sel = az_reg; r_sel = rx_reg; end
            2'd1:    begin a_sel = ay_reg; b_sel = ax_reg; c_sel = az_reg; r_sel = ry_reg; end
            default: begin a_sel = az_reg; b_sel = ax_reg; c_sel = ay_reg; r_sel = rz_reg; end
        endcase
    end

    // Sample capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x; ay_reg <= accel_y; az_reg <= accel_z;
            rx_reg <= rate_x;  ry_reg <= rate_y;  rz_reg <= rate_z;
        end
    end

    // Radicand: b*b+c*c is taken in the init step (two 16x16 products),
    // then a restoring root, one bit per cycle
    assign sq_trial = {rem_reg[31:0], rad_reg[31:30]} - {15'd0, root_reg, 2'b01};
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        if (!sq_trial[33])
        begin
            rem_next  = sq_trial[32:0];
            root_next = {root_reg[15:0], 1'b1};
        end
        else
        begin
            rem_next  = {rem_reg[30:0], rad_reg[31:30]};
            root_next = {root_reg[15:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rad_reg  <= 32'(b_sel * b_sel) + 32'(c_sel * c_sel);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[29:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    // CORDIC vectoring, one iteration per cycle; >>> is a floor shift
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.cor_init)
        begin
            x_reg <= CW'({root_reg[16:1], 16'd0});
            y_reg <= CW'({{(CW-32){a_sel[ACC_W-1]}}, a_sel, 16'd0});
            z_reg <= '0;
            i_reg <= '0;
        end
        else if (cmd.cor_step)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_lut(i_reg);
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_lut(i_reg);
            end
            i_reg <= i_reg + 5'd1;
        end
    end

    // Accel tilt with the degenerate case of zero magnitude
    assign z_rnd = (z_reg + RND_Z) >>> (24 - F);
    always_comb
    begin
        if (root_reg[16:1] != '0)
            cor_ang = (TILT_W+2)'(z_rnd);
        else if (a_sel > 0)
            cor_ang = (TILT_W+2)'(DEG90);
        else if (a_sel < 0)
            cor_ang = -(TILT_W+2)'(DEG90);
        else
            cor_ang = '0;
    end

    // Gyro numerator then divide by 1000 with round half away from zero
    assign gnum  = GNW'(r_sel * $signed({1'b0, step_time_ms})) <<< F;
    assign qprod = (RSH+GMW+1)'(gmag_reg) * (RSH+GMW+1)'(RECIP);
    assign r0    = (GMW+2)'(gmag_reg) + (GMW+2)'(500) - (GMW+2)'(q0_reg) * (GMW+2)'(1000);
    assign q1    = (r0 >= (GMW+2)'(1000)) ? q0_reg + GMW'(1) : q0_reg;

    // Numerator magnitude is taken while the CORDIC starts, the quotient estimate in the gyro multiply state
    always_ff @(posedge clk)
    begin
        if (cmd.cor_init)
        begin
            gneg_reg <= gnum[GNW-1];
            gmag_reg <= gnum[GNW-1] ? GMW'(-gnum) : GMW'(gnum);
        end
        if (cmd.gyro_mul)
        begin
            q0_reg  <= GMW'(qprod >> RSH);
            acc_reg <= cor_ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gyro_div)
            gyro_reg <= (TILT_W+3)'(ang_reg[cmd.axis]) +
                        (gneg_reg ? -(TILT_W+3)'(q1) : (TILT_W+3)'(q1));
    end

    assign w_eff = (blend_weight > 9'd256) ? 10'd256 : {1'b0, blend_weight};
    always_ff @(posedge clk)
    begin
        if (cmd.blend_mul)
            sum_reg <= BW'(acc_reg) * BW'($signed({1'b0, w_eff}))
                     + BW'(gyro_reg) * BW'($signed(10'd256 - w_eff)) + BW'(128);
    end

    assign vsh  = sum_reg >>> 8;
    assign vsat = (vsh > BW'(8388607)) ? 24'sh7FFFFF :
                  (vsh < -BW'(8388608)) ? 24'sh800000 : vsh[TILT_W-1:0];

    // Angle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
                ang_reg[k] <= '0;
        end
        else if (cmd.store)
        begin
            ang_reg[cmd.axis] <= vsat;
        end
    end

    // Result word, loaded as the last axis is stored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
                res_reg[k] <= '0;
        end
        else if (cmd.store && cmd.axis == 2'd2)
        begin
            res_reg[0] <= ang_reg[0];
            res_reg[1] <= ang_reg[1];
            res_reg[2] <= vsat;
        end
    end

    assign tilt_x = res_reg[0];
    assign tilt_y = res_reg[1];
    assign tilt_z = res_reg[2];

endmodule

FILE: hdl/imu_tilt_complementary_filter.sv
// Channel      | dir | words
// samp         | in  | accel_x/y/z, rate_x/y/z (16b signed each)
// tilt         | out | tilt_x/y/z (24b signed, 1/64 degree)
// cfg          | in  | cfg_we, cfg_index, cfg_data
// Each item runs its 3 axes in turn through the bit-serial root and the shared CORDIC
// unit; a new sample is accepted only once the sequencer is back in idle.
// Reset clears the angles and loads the default weight and step.
// A finished result word waits in its output register while the next sample is
// computed; that sample's last axis store stalls until the word has drained.
// Top level of the complementary tilt filter. Depends on imu_tcf_pkg, imu_tcf_if,
// imu_tcf_ctrl and imu_tcf_dp.
`timescale 1ns / 1ps
module imu_tilt_complementary_filter
    import imu_tcf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int CORDIC_STEPS    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    imu_tcf_in_if.sink            samp,
    imu_tcf_out_if.source         tilt,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    imu_tcf_cmd_t        cmd;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [STEP_W-1:0]   step_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLEND_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_STEP_TIME:    step_reg   <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    imu_tcf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(samp.valid), .in_ready(samp.ready),
        .out_valid(tilt.valid), .out_ready(tilt.ready),
        .cmd(cmd)
    );

    imu_tcf_dp #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .accel_x(samp.accel_x), .accel_y(samp.accel_y), .accel_z(samp.accel_z),
        .rate_x(samp.rate_x), .rate_y(samp.rate_y), .rate_z(samp.rate_z),
        .blend_weight(weight_reg), .step_time_ms(step_reg),
        .tilt_x(tilt.tilt_x), .tilt_y(tilt.tilt_y), .tilt_z(tilt.tilt_z)
    );

endmodule
